// File: rtl/core/pwrrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwrrf_pkg;

    localparam int BYTE_W = 8;
    localparam int VALUE_W = 16;
    localparam int IN_SLOT_W = 4;
    localparam int CFG_INDEX_W = 1;

    // Operation codes
    localparam logic OP_POST = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_TOKEN = 1'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd192;
    localparam logic [BYTE_W-1:0] REPLY_TOKEN_RESET = 8'd96;
    localparam logic [BYTE_W-1:0] FRAME_PAYLOAD_LEN = 8'd3;

    // Position of each byte in a reply frame
    typedef enum logic [2:0] {
        FB_START    = 3'd0,
        FB_TOKEN    = 3'd1,
        FB_LENGTH   = 3'd2,
        FB_SLOT     = 3'd3,
        FB_VALUE_LO = 3'd4,
        FB_VALUE_HI = 3'd5,
        FB_CHECKSUM = 3'd6
    } frame_pos_t;

endpackage

`default_nettype wire

// File: rtl/core/pending_write_round_robin_framer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                   | Payload
// ----------+-----------------------------+------------------------------------------
// command   | start, accepted if !busy    | opcode, slot_index, write_value
// result    | valid, cannot be stalled    | frame_byte, last_byte, empty_reply
// config    | cfg_we, no wait             | cfg_index, cfg_data
//
// A post leaves busy low. A poll walks the pending flags one slot per cycle,
// then sends seven frame bytes, or one empty_reply byte if no flag is set;
// the value comes from the slot RAM, read in the cycle the slot is found.
// Reset clears all pending flags at once; no clearing pass. Results
// cannot be stalled: each appears for exactly one cycle.

module pending_write_round_robin_framer #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                opcode,
    input  wire logic [pwrrf_pkg::IN_SLOT_W-1:0]     slot_index,
    input  wire logic [pwrrf_pkg::VALUE_W-1:0]       write_value,
    output logic                                     valid,
    output logic      [pwrrf_pkg::BYTE_W-1:0]        frame_byte,
    output logic                                     last_byte,
    output logic                                     empty_reply,
    input  wire logic                                cfg_we,
    input  wire logic [pwrrf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pwrrf_pkg::BYTE_W-1:0]        cfg_data
);

    import pwrrf_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEND
    } state_t;

    state_t                  state_reg;
    logic [SLOT_COUNT-1:0]   pend_reg;
    logic [SLOT_W-1:0]       last_served_reg;
    logic [SLOT_W-1:0]       idx_reg;
    logic [SLOT_W-1:0]       count_reg;
    frame_pos_t              pos_reg;
    logic [BYTE_W-1:0]       start_byte_reg;
    logic [BYTE_W-1:0]       reply_token_reg;
    logic                    valid_reg;
    logic [BYTE_W-1:0]       frame_byte_reg;
    logic                    last_byte_reg;
    logic                    empty_reply_reg;

    logic                    cmd_accept;
    logic                    slot_ok;
    logic                    ram_we;
    logic [SLOT_W-1:0]       post_slot;
    logic [SLOT_W-1:0]       idx_next;
    logic [SLOT_W-1:0]       first_idx;
    logic [VALUE_W-1:0]      slot_value;
    logic [BYTE_W-1:0]       slot_byte;
    logic [BYTE_W-1:0]       checksum;
    logic [BYTE_W-1:0]       send_byte;

    assign busy        = (state_reg != ST_IDLE);
    assign valid       = valid_reg;
    assign frame_byte  = frame_byte_reg;
    assign last_byte   = last_byte_reg;
    assign empty_reply = empty_reply_reg;

    assign cmd_accept = start && (state_reg == ST_IDLE);
    assign slot_ok    = (int'(slot_index) < SLOT_COUNT);
    assign post_slot  = SLOT_W'(slot_index);
    assign ram_we     = cmd_accept && (opcode == OP_POST) && slot_ok;

    assign first_idx = (last_served_reg == LAST_SLOT) ? '0 : last_served_reg + 1'b1;
    assign idx_next  = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;

    pwrrf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (post_slot),
        .wdata (write_value),
        .raddr (idx_reg),
        .rdata (slot_value)
    );

    assign slot_byte = 8'(idx_reg);
    assign checksum  = start_byte_reg ^ reply_token_reg ^ FRAME_PAYLOAD_LEN ^ slot_byte
                     ^ slot_value[7:0] ^ slot_value[15:8];

    always_comb
    begin
        case (pos_reg)
            FB_START:    send_byte = start_byte_reg;
            FB_TOKEN:    send_byte = reply_token_reg;
            FB_LENGTH:   send_byte = FRAME_PAYLOAD_LEN;
            FB_SLOT:     send_byte = slot_byte;
            FB_VALUE_LO: send_byte = slot_value[7:0];
            FB_VALUE_HI: send_byte = slot_value[15:8];
            default:     send_byte = checksum;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RESET;
            reply_token_reg <= REPLY_TOKEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE:  start_byte_reg  <= cfg_data;
                CFG_REPLY_TOKEN: reply_token_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pend_reg        <= '0;
            last_served_reg <= '0;
            idx_reg         <= '0;
            count_reg       <= '0;
            pos_reg         <= FB_START;
            valid_reg       <= 1'b0;
            frame_byte_reg  <= '0;
            last_byte_reg   <= 1'b0;
            empty_reply_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        if (opcode == OP_POST)
                        begin
                            if (slot_ok)
                            begin
                                pend_reg[post_slot] <= 1'b1;
                            end
                        end
                        else
                        begin
                            idx_reg   <= first_idx;
                            count_reg <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (pend_reg[idx_reg])
                    begin
                        // hold idx so the RAM keeps returning this slot's value
                        pend_reg[idx_reg] <= 1'b0;
                        last_served_reg   <= idx_reg;
                        pos_reg           <= FB_START;
                        state_reg         <= ST_SEND;
                    end
                    else if (count_reg == LAST_SLOT)
                    begin
                        valid_reg       <= 1'b1;
                        frame_byte_reg  <= '0;
                        last_byte_reg   <= 1'b1;
                        empty_reply_reg <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_next;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                ST_SEND:
                begin
                    valid_reg       <= 1'b1;
                    frame_byte_reg  <= send_byte;
                    empty_reply_reg <= 1'b0;
                    if (pos_reg == FB_CHECKSUM)
                    begin
                        last_byte_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        last_byte_reg <= 1'b0;
                        pos_reg       <= frame_pos_t'(pos_reg + 3'd1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pwrrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pwrrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
